// File: sv/atcm_pkg.sv
// Shared types, widths, mode codes and the weight tables of the anaglyph tint matrix.
package atcm_pkg;

    localparam int PIX_W    = 8;
    localparam int WEIGHT_W = 16;
    localparam int FRAC_W   = 14;
    localparam int PROD_W   = PIX_W + 1 + WEIGHT_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int MODE_W   = 3;

    localparam logic [MODE_W-1:0] MODE_IDENTITY  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRUE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALF      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OPTIMIZED = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUBOIS    = 3'd5;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));
    localparam logic [PIX_W-1:0] PIX_MAX    = {PIX_W{1'b1}};

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
    } pixel_out_t;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef weight_t [2:0] weight_row_t;
    typedef weight_row_t [2:0] weight_mat_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t [2:0] sum_vec_t;

    // Rows are output channels, columns are input channels R, G, B (index 0 is R).
    function automatic weight_row_t mk_row(input int r, input int g, input int b);
        weight_row_t row;
        row[0] = WEIGHT_W'(r);
        row[1] = WEIGHT_W'(g);
        row[2] = WEIGHT_W'(b);
        return row;
    endfunction

    function automatic weight_mat_t mode_weights(input logic [MODE_W-1:0] mode);
        weight_mat_t m;
        unique case (mode)
            MODE_GRAY:
            begin
                m[0] = mk_row(4899, 9617, 1868);
                m[1] = mk_row(4899, 9617, 1868);
                m[2] = mk_row(4899, 9617, 1868);
            end
            MODE_TRUE:
            begin
                m[0] = mk_row(4899, 9617, 1868);
                m[1] = mk_row(0, 0, 0);
                m[2] = mk_row(4899, 9617, 1868);
            end
            MODE_HALF:
            begin
                m[0] = mk_row(4899, 9617, 1868);
                m[1] = mk_row(0, 16384, 0);
                m[2] = mk_row(0, 0, 16384);
            end
            MODE_OPTIMIZED:
            begin
                m[0] = mk_row(0, 11469, 4915);
                m[1] = mk_row(0, 16384, 0);
                m[2] = mk_row(0, 0, 16384);
            end
            MODE_DUBOIS:
            begin
                m[0] = mk_row(6627, 7120, 2636);
                m[1] = mk_row(5403, 11221, -239);
                m[2] = mk_row(-1904, -3116, 21461);
            end
            default:
            begin
                // Identity, also used for the two codes without meaning.
                m[0] = mk_row(16384, 0, 0);
                m[1] = mk_row(0, 16384, 0);
                m[2] = mk_row(0, 0, 16384);
            end
        endcase
        return m;
    endfunction

endpackage

// File: sv/atcm_coef_stage.sv
// First stage: registers the pixel together with the weight matrix of the current mode.
module atcm_coef_stage
    import atcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  pixel_in_t           in_pixel,
    input  logic [MODE_W-1:0]   mode,
    output logic                out_valid,
    output pixel_in_t           out_pixel,
    output weight_mat_t         out_weights
);

    logic        valid_reg;
    pixel_in_t   pixel_reg;
    weight_mat_t weights_reg;
    weight_mat_t weights_next;

    assign weights_next = mode_weights(mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            pixel_reg   <= in_pixel;
            weights_reg <= weights_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_pixel   = pixel_reg;
    assign out_weights = weights_reg;

endmodule

// File: sv/atcm_mac_stage.sv
// Second and third stages: nine products, registered, then three row sums, registered.
module atcm_mac_stage
    import atcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  pixel_in_t   in_pixel,
    input  weight_mat_t in_weights,
    output logic        out_valid,
    output sum_vec_t    out_sums
);

    logic [PIX_W-1:0] px [3];
    prod_t            prod_next [3][3];
    prod_t            prod_reg  [3][3];
    logic             prod_valid_reg;
    sum_vec_t         sum_next;
    sum_vec_t         sum_reg;
    logic             sum_valid_reg;

    assign px[0] = in_pixel.red_in;
    assign px[1] = in_pixel.green_in;
    assign px[2] = in_pixel.blue_in;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[ch][k] = prod_t'($signed({1'b0, px[k]}))
                                 * prod_t'(in_weights[ch][k]);
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = sum_t'(prod_reg[ch][0]) + sum_t'(prod_reg[ch][1])
                         + sum_t'(prod_reg[ch][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (prod_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_sums  = sum_reg;

endmodule

// File: sv/atcm_round_stage.sv
// Last stage: rounds each Q13.14 sum to an integer and clamps it to the pixel range.
module atcm_round_stage
    import atcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  sum_vec_t   in_sums,
    output logic       out_valid,
    output pixel_out_t out_pixel
);

    logic [PIX_W-1:0] chan_next [3];
    logic             valid_reg;
    pixel_out_t       pixel_reg;

    always_comb
    begin
        sum_t                   t;
        logic [SUM_W-FRAC_W-1:0] whole;
        for (int ch = 0; ch < 3; ch++)
        begin
            t     = in_sums[ch] + $signed(ROUND_HALF);
            whole = t[SUM_W-1:FRAC_W];
            priority if (t[SUM_W-1])
            begin
                chan_next[ch] = '0;
            end
            else if (whole > (SUM_W-FRAC_W)'(PIX_MAX))
            begin
                chan_next[ch] = PIX_MAX;
            end
            else
            begin
                chan_next[ch] = whole[PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            pixel_reg.red_out   <= chan_next[0];
            pixel_reg.green_out <= chan_next[1];
            pixel_reg.blue_out  <= chan_next[2];
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// File: sv/anaglyph_tint_color_matrix.sv
// Top level of the anaglyph tint color matrix: register port and four-stage pixel pipeline.
//
// One pixel item is taken at every clock edge where start is high; busy is always low.
// Each item's result appears on result with done high, for a single cycle, once it has passed
// the four register stages, and the receiver cannot stall it. The rate of one item per clock
// is set by the four register stages: weight select, the nine multipliers, the three row
// adders, and the round and clamp stage. tint_mode is written through the APB port at
// byte address 0 and must only change while no item is in flight; codes 6 and 7 act as
// identity.
module anaglyph_tint_color_matrix
    import atcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  pixel_in_t   pixel,
    output logic        done,
    output pixel_out_t  result
);

    localparam logic REG_TINT_MODE = 1'b0;

    logic [MODE_W-1:0] tint_mode_reg;
    logic [MODE_W-1:0] tint_mode_next;
    logic              reg_index;
    logic              wr_en;
    logic              in_valid;
    logic              s1_valid;
    pixel_in_t         s1_pixel;
    weight_mat_t       s1_weights;
    logic              s3_valid;
    sum_vec_t          s3_sums;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;

    always_comb
    begin
        tint_mode_next = tint_mode_reg;
        if (wr_en && reg_index == REG_TINT_MODE)
        begin
            tint_mode_next = pwdata[MODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_mode_reg <= MODE_IDENTITY;
        end
        else
        begin
            tint_mode_reg <= tint_mode_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_TINT_MODE: prdata = {{(32-MODE_W){1'b0}}, tint_mode_reg};
            default:       prdata = '0;
        endcase
    end

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    atcm_coef_stage u_coef
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_pixel    (pixel),
        .mode        (tint_mode_reg),
        .out_valid   (s1_valid),
        .out_pixel   (s1_pixel),
        .out_weights (s1_weights)
    );

    atcm_mac_stage u_mac
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_pixel   (s1_pixel),
        .in_weights (s1_weights),
        .out_valid  (s3_valid),
        .out_sums   (s3_sums)
    );

    atcm_round_stage u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_sums   (s3_sums),
        .out_valid (done),
        .out_pixel (result)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the anaglyph tint color matrix: APB mode writes plus a pixel stream.
`timescale 1ns / 100ps

module tb;
    import atcm_pkg::*;

    localparam logic [2:0] MODE_SPARE6    = 3'd6;
    localparam logic [2:0] ADDR_TINT_MODE = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;
    localparam int TINT_ROUND  = 1 << 13;
    localparam int TINT_SHIFT  = 14;
    localparam int SETTLE_CYC  = 8;
    localparam int QUIET_LIMIT = 2000;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start   = 1'b0;
    logic        busy;
    pixel_in_t   pixel   = '0;
    logic        done;
    pixel_out_t  result;

    // Q2.14 weights per mode, rows are output channels, columns are R, G, B.
    int tint_coef [8][3][3] = '{
        '{'{16384, 0, 0}, '{0, 16384, 0}, '{0, 0, 16384}},
        '{'{4899, 9617, 1868}, '{4899, 9617, 1868}, '{4899, 9617, 1868}},
        '{'{4899, 9617, 1868}, '{0, 0, 0}, '{4899, 9617, 1868}},
        '{'{4899, 9617, 1868}, '{0, 16384, 0}, '{0, 0, 16384}},
        '{'{0, 11469, 4915}, '{0, 16384, 0}, '{0, 0, 16384}},
        '{'{6627, 7120, 2636}, '{5403, 11221, -239}, '{-1904, -3116, 21461}},
        '{'{16384, 0, 0}, '{0, 16384, 0}, '{0, 0, 16384}},
        '{'{16384, 0, 0}, '{0, 16384, 0}, '{0, 0, 16384}}
    };

    logic [2:0] tint_setting = MODE_IDENTITY;
    pixel_in_t  pixel_backlog [$];
    pixel_out_t tinted_due [$];
    bit         gaps_on = 1'b1;
    int         gap_left = 0;
    int         pixels_sent = 0;
    int         pixels_checked = 0;
    int         reg_writes = 0;
    int         error_count = 0;
    int         quiet_cycles = 0;
    bit         [7:0] modes_run = '0;

    anaglyph_tint_color_matrix u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .pixel   (pixel),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    function automatic pixel_out_t tint_pixel(input logic [2:0] mode, input pixel_in_t px);
        int chan [3];
        int lvl [3];
        int acc;
        pixel_out_t res;
        chan[0] = int'(px.red_in);
        chan[1] = int'(px.green_in);
        chan[2] = int'(px.blue_in);
        for (int c = 0; c < 3; c++)
        begin
            acc = TINT_ROUND;
            for (int k = 0; k < 3; k++)
                acc += tint_coef[mode][c][k] * chan[k];
            if (acc < 0)
                lvl[c] = 0;
            else
            begin
                lvl[c] = acc >>> TINT_SHIFT;
                if (lvl[c] > 255)
                    lvl[c] = 255;
            end
        end
        res.red_out   = 8'(lvl[0]);
        res.green_out = 8'(lvl[1]);
        res.blue_out  = 8'(lvl[2]);
        return res;
    endfunction

    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_level();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'h00;
        if (roll == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void queue_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        pixel_in_t px;
        px.red_in   = r;
        px.green_in = g;
        px.blue_in  = b;
        pixel_backlog.insert(pixel_backlog.size(), px);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes one register, then reads the mode back to confirm what the block now holds.
    task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] rd;
        reg_access(1'b1, addr, value, rd);
        if (addr == ADDR_TINT_MODE)
            tint_setting = value[2:0];
        reg_writes++;
        reg_access(1'b0, ADDR_TINT_MODE, '0, rd);
        if (rd !== {29'd0, tint_setting})
            report_mismatch($sformatf("tint_mode reads %0h, expected %0d", rd, tint_setting));
    endtask

    task automatic wait_drained();
        while (pixel_backlog.size() != 0 || start || tinted_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Pixel driver: holds an item until it is taken, then inserts a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            pixel    <= '0;
            gap_left <= 0;
        end
        else if (!(start && busy))
        begin
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pixel_backlog.size() != 0)
            begin
                start    <= 1'b1;
                pixel    <= pixel_backlog.pop_front();
                gap_left <= idle_span();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predicts on every accepted item and checks every result strobe.
    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (tinted_due.size() == 0)
                    report_mismatch($sformatf("result %h with nothing outstanding", result));
                else
                begin
                    want = tinted_due.pop_front();
                    if (result.red_out !== want.red_out)
                        report_mismatch($sformatf("red_out %0d, expected %0d",
                                                  result.red_out, want.red_out));
                    if (result.green_out !== want.green_out)
                        report_mismatch($sformatf("green_out %0d, expected %0d",
                                                  result.green_out, want.green_out));
                    if (result.blue_out !== want.blue_out)
                        report_mismatch($sformatf("blue_out %0d, expected %0d",
                                                  result.blue_out, want.blue_out));
                    pixels_checked++;
                end
            end
            if (start && !busy)
            begin
                tinted_due.insert(tinted_due.size(), tint_pixel(tint_setting, pixel));
                pixels_sent++;
                modes_run[tint_setting] = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", tinted_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        logic [2:0] mode_order [16];
        int         count;
        int         pick;
        logic [2:0] tmp;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value of the mode is identity.
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h55, 8'hAA, 8'h0F);
        wait_drained();

        // A write to an address past the register list must leave the mode alone.
        set_register(ADDR_UNMAPPED, {29'd0, MODE_DUBOIS});
        queue_pixel(8'hA5, 8'h5A, 8'hC3);
        queue_pixel(8'h01, 8'h80, 8'hFE);
        wait_drained();

        // Dubois has negative weights and a blue gain above one: both clamps are hit here.
        set_register(ADDR_TINT_MODE, {29'd0, MODE_DUBOIS});
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'hFF, 8'h00, 8'h00);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        queue_pixel(8'h00, 8'h00, 8'hFF);
        queue_pixel(8'hFF, 8'hFF, 8'h00);
        queue_pixel(8'h00, 8'hFF, 8'hFF);
        queue_pixel(8'hFF, 8'h00, 8'hFF);
        wait_drained();

        // Codes without meaning act as identity; upper data bits are dropped.
        set_register(ADDR_TINT_MODE, 32'hFFFF_FFFF);
        queue_pixel(8'h12, 8'hED, 8'h7F);
        queue_pixel(8'hFF, 8'h00, 8'h80);
        wait_drained();
        set_register(ADDR_TINT_MODE, {29'd0, MODE_SPARE6});
        queue_pixel(8'h80, 8'h7F, 8'h00);
        queue_pixel(8'h3C, 8'hC3, 8'hFF);
        wait_drained();

        // Random phases: every mode code twice, in shuffled order.
        for (int i = 0; i < 16; i++)
            mode_order[i] = 3'(i % 8);
        for (int i = 15; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            tmp = mode_order[i];
            mode_order[i] = mode_order[pick];
            mode_order[pick] = tmp;
        end
        for (int p = 0; p < 16; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                set_register(ADDR_TINT_MODE,
                             {29'($urandom_range(0, 32'h1FFF_FFFF)), mode_order[p]});
            else
                set_register(ADDR_TINT_MODE, {29'd0, mode_order[p]});
            gaps_on = ($urandom_range(0, 3) != 0);
            count = $urandom_range(20, 36);
            for (int n = 0; n < count; n++)
                queue_pixel(random_level(), random_level(), random_level());
            wait_drained();
        end

        $display("Drove %0d pixels, checked %0d tinted results, %0d register writes.",
                 pixels_sent, pixels_checked, reg_writes);
        $display("Mode codes exercised (bit per code): %b, mismatches: %0d",
                 modes_run, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
